>>> rtl/cjk_line_break_inserter_top_defines.svh
// Assertion macros for the line-break inserter.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef CJK_LINE_BREAK_INSERTER_TOP_DEFINES_SVH
`define CJK_LINE_BREAK_INSERTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CLBI_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("clbi: same-cycle check failed");
`define CLBI_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("clbi: next-cycle check failed");
`else
`define CLBI_ASSERT_NOW(label, clk, rst_n, cond, cons)
`define CLBI_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

>>> rtl/clbi_pkg.sv
`timescale 1ns / 1ps
package clbi_pkg;

    localparam int unsigned CODE_W = 16;

    localparam logic [CODE_W-1:0] TAB_CODE    = 16'h0009;
    localparam logic [CODE_W-1:0] ZWSP_CODE   = 16'h200B;
    localparam logic [CODE_W-1:0] LOWER_LIMIT = 16'h0100;
    localparam logic [CODE_W-1:0] SEP_RESET   = 16'h200B;

    // up to three words come out of one input word
    localparam int unsigned MAX_WORDS = 3;

    typedef struct packed {
        logic collapse;   // both held and incoming are tab or zero-width space
        logic allow;      // a break may go between them
    } t_pair_info;

    typedef struct packed {
        logic [MAX_WORDS-1:0][CODE_W-1:0] code;  // code[0] goes out first
        logic [1:0]                       count;
        logic                             last;  // final word carries tlast
    } t_bundle;

    typedef struct packed {
        logic       free;   // bundle register can take a new bundle this cycle
        logic [1:0] count;
    } t_emit_stat;

    function automatic logic is_gap(input logic [CODE_W-1:0] c);
        return (c == TAB_CODE) || (c == ZWSP_CODE);
    endfunction

    function automatic logic no_break_before(input logic [CODE_W-1:0] c);
        logic hit;
        case (c)
            16'h000D, 16'h000A, 16'h0009, 16'h0020, 16'h0021, 16'h0025, 16'h0029, 16'h002C,
            16'h002E, 16'h003A, 16'h003B, 16'h003E, 16'h003F, 16'h005D, 16'h007D, 16'h00A2,
            16'h00A8, 16'h00B0, 16'h00B7, 16'h02C7, 16'h02C9, 16'h2015, 16'h2016, 16'h2019,
            16'h201D, 16'h201E, 16'h201F, 16'h2020, 16'h2021, 16'h203A, 16'h2103, 16'h2236,
            16'h3001, 16'h3002, 16'h3003, 16'h3006, 16'h3008, 16'h300A, 16'h300C, 16'h300E,
            16'h3015, 16'h3017, 16'h301E, 16'hFE35, 16'hFE39, 16'hFE3D, 16'hFE3F, 16'hFE43,
            16'hFE58, 16'hFE5A, 16'hFE5C, 16'hFF01, 16'hFF02, 16'hFF05, 16'hFF07, 16'hFF09,
            16'hFF0C, 16'hFF0E, 16'hFF1A, 16'hFF1B, 16'hFF1F, 16'hFF3D, 16'hFF40, 16'hFF5C,
            16'hFF5D, 16'hFF5E: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic no_break_after(input logic [CODE_W-1:0] c);
        logic hit;
        case (c)
            16'h000D, 16'h000A, 16'h0009, 16'h0020, 16'h0024, 16'h0028, 16'h002A, 16'h002C,
            16'h00A3, 16'h00A5, 16'h00B7, 16'h2018, 16'h201C, 16'h3008, 16'h300A, 16'h300C,
            16'h300E, 16'h3010, 16'h3014, 16'h3016, 16'h301D, 16'hFE57, 16'hFE59, 16'hFE5B,
            16'hFF04, 16'hFF08, 16'hFF0E, 16'hFF3B, 16'hFF5B, 16'hFFE1,
            16'hFFE5: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

>>> rtl/clbi_brk.sv
`timescale 1ns / 1ps
module clbi_brk (
    input  logic [clbi_pkg::CODE_W-1:0] i_held,
    input  logic [clbi_pkg::CODE_W-1:0] i_code,
    output clbi_pkg::t_pair_info         o_info
);
    import clbi_pkg::*;

    logic w_gap_a;
    logic w_gap_b;
    logic w_both_low;

    assign w_gap_a    = is_gap(i_held);
    assign w_gap_b    = is_gap(i_code);
    assign w_both_low = (i_held < LOWER_LIMIT) && (i_code < LOWER_LIMIT);

    assign o_info.collapse = w_gap_a && w_gap_b;
    assign o_info.allow    = !w_gap_a && !w_gap_b && !w_both_low
                             && !no_break_after(i_held) && !no_break_before(i_code);

endmodule

>>> rtl/clbi_emit.sv
`timescale 1ns / 1ps
module clbi_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  clbi_pkg::t_bundle           i_bundle,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [clbi_pkg::CODE_W-1:0] m_axis_tdata,   // [15:0] out_code
    output logic                        m_axis_tlast,   // out_last
    output clbi_pkg::t_emit_stat        o_stat
);
    import clbi_pkg::*;

    logic [MAX_WORDS-1:0][CODE_W-1:0] r_code;
    logic [1:0]                       r_count;
    logic                             r_last;

    logic w_take;

    assign w_take        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_count != 2'd0);
    assign m_axis_tdata  = r_code[0];
    // only the final word of a bundle may carry the end mark
    assign m_axis_tlast  = r_last && (r_count == 2'd1);

    assign o_stat.free  = (r_count == 2'd0) || ((r_count == 2'd1) && m_axis_tready);
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_last  <= 1'b0;
        end else if (i_load) begin
            r_count <= i_bundle.count;
            r_last  <= i_bundle.last;
        end else if (w_take) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= i_bundle.code;
        end else if (w_take) begin
            r_code[0] <= r_code[1];
            r_code[1] <= r_code[2];
        end
    end

endmodule

>>> rtl/cjk_line_break_inserter_top.sv
`timescale 1ns / 1ps
// CJK line-break inserter.
// s_axis carries one code point per word (tdata) with tlast on the final character
// of a string. m_axis carries characters and inserted separators, tlast on the final
// character of each string. The cfg channel writes the separator code point; it is
// always ready and should only be written while the block is idle.
// Each input word yields zero to three output words: nothing while a character is
// first held or a tab/zero-width-space run collapses mid-string; the final character
// alone for a one-character string or a run collapsing at end of string; otherwise the
// held character, an optional separator and, at end of string, the final character.
// Each taken word is registered, then becomes a bundle for the bundle register.
// Throughput: one input word per cycle while m_axis is ready and each yields at most
// one output word; otherwise the output bundle register sets the pace at one output
// word per cycle while m_axis is ready, as a new bundle loads only as the last word
// of the current one leaves. When m_axis stalls, the bundle holds and s_axis_tready
// drops once the input register is full. Reset empties the input register and the
// bundle, clears the held character and sets the separator to zero-width space.
module cjk_line_break_inserter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [clbi_pkg::CODE_W-1:0] i_cfg_data,      // [15:0] separator_code
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [clbi_pkg::CODE_W-1:0] s_axis_tdata,    // [15:0] code_point
    input  logic                        s_axis_tlast,    // end_of_string
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [clbi_pkg::CODE_W-1:0] m_axis_tdata,    // [15:0] out_code
    output logic                        m_axis_tlast     // out_last
);
    import clbi_pkg::*;

    logic [CODE_W-1:0] r_sep;
    logic              r_in_valid;
    logic [CODE_W-1:0] r_in_code;
    logic              r_in_eos;
    logic [CODE_W-1:0] r_held_code;
    logic              r_held_valid;
    logic [CODE_W-1:0] n_held_code;
    logic              n_held_valid;

    t_pair_info w_info;
    t_bundle    w_bundle;
    t_emit_stat w_stat;
    logic       w_load;
    logic       w_in_take;

    assign o_cfg_ready   = 1'b1;
    assign w_load        = r_in_valid && w_stat.free;
    assign s_axis_tready = !r_in_valid || w_stat.free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sep <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_code <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    clbi_brk u_brk (
        .i_held (r_held_code),
        .i_code (r_in_code),
        .o_info (w_info)
    );

    always_comb begin
        w_bundle.code[0] = r_in_code;
        w_bundle.code[1] = r_in_code;
        w_bundle.code[2] = r_in_code;
        w_bundle.count   = 2'd0;
        w_bundle.last    = r_in_eos;
        n_held_code      = r_held_code;
        n_held_valid     = r_held_valid;
        if (!r_held_valid) begin
            // single-word string goes straight out, otherwise start holding
            w_bundle.count = {1'b0, r_in_eos};
            n_held_valid   = !r_in_eos;
            if (!r_in_eos) begin
                n_held_code = r_in_code;
            end
        end else if (w_info.collapse) begin
            // later gap is dropped; at end of string it replaces the held one
            w_bundle.count = {1'b0, r_in_eos};
            if (r_in_eos) begin
                n_held_valid = 1'b0;
                n_held_code  = '0;
            end
        end else begin
            w_bundle.code[0] = r_held_code;
            w_bundle.code[1] = w_info.allow ? r_sep : r_in_code;
            w_bundle.count   = 2'd1 + {1'b0, w_info.allow} + {1'b0, r_in_eos};
            n_held_valid     = !r_in_eos;
            n_held_code      = r_in_eos ? '0 : r_in_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_code  <= '0;
        end else if (w_load) begin
            r_held_valid <= n_held_valid;
            r_held_code  <= n_held_code;
        end
    end

    clbi_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_bundle      (w_bundle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_stat        (w_stat)
    );

`include "cjk_line_break_inserter_top_defines.svh"

    // end of string always leaves nothing held
    `CLBI_ASSERT_NEXT(a_eos_clears_hold, i_clk, i_rst_n, w_load && r_in_eos, !r_held_valid)
    // a collapsed gap mid-string keeps the first gap of the run
    `CLBI_ASSERT_NEXT(a_collapse_keeps, i_clk, i_rst_n, w_load && r_held_valid && w_info.collapse && !r_in_eos, $stable(r_held_code) && r_held_valid)
    // end mark only on the final word of a bundle
    `CLBI_ASSERT_NOW(a_last_single, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, w_stat.count == 2'd1)

endmodule
